[hdl/dqn_pkg.sv]
// Shared types, widths and the saturation helper for the dual quaternion normalizer.
// No dependencies; every other file refers to this package by scoped names.
package dqn_pkg;

   localparam int unsigned DATA_W     = 32;                 // Q16.16 component width
   localparam int unsigned FRAC_W     = 16;                 // fraction bits
   localparam int unsigned COMP_NUM   = 4;                  // components per quaternion
   localparam int unsigned SQ_W       = 2 * DATA_W;         // one squared magnitude
   localparam int unsigned SUM_W      = SQ_W + 1;           // sum of four squares (max 2^64)
   localparam int unsigned ROOT_W     = DATA_W + 1;         // length, 0 .. 2^32
   localparam int unsigned DIVIDEND_W = DATA_W + FRAC_W;    // |v| << 16
   localparam int unsigned DIV_LAT    = DIVIDEND_W + 1;     // bit steps plus sign/saturate
   localparam int unsigned WIDE_W     = 66;                 // headroom for sums before saturation

   typedef logic signed [DATA_W-1:0] fixed_type;
   typedef fixed_type [COMP_NUM-1:0] quat_type;

   typedef struct packed {
      fixed_type real_w;
      fixed_type real_x;
      fixed_type real_y;
      fixed_type real_z;
      fixed_type dual_w;
      fixed_type dual_x;
      fixed_type dual_y;
      fixed_type dual_z;
   } req_payload_type;

   typedef struct packed {
      fixed_type out_real_w;
      fixed_type out_real_x;
      fixed_type out_real_y;
      fixed_type out_real_z;
      fixed_type out_dual_w;
      fixed_type out_dual_x;
      fixed_type out_dual_y;
      fixed_type out_dual_z;
      logic      zero_length;
   } rsp_payload_type;

   localparam logic signed [WIDE_W-1:0] FIXED_MAX = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] FIXED_MIN = -66'sd2147483648;

   // Clamp a wide signed value to the 32-bit range.
   function automatic fixed_type sat_fixed(input logic signed [WIDE_W-1:0] v);
      fixed_type r;
      if (v > FIXED_MAX) begin
         r = fixed_type'(FIXED_MAX);
      end else if (v < FIXED_MIN) begin
         r = fixed_type'(FIXED_MIN);
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[hdl/dqn_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on dqn_pkg for the payload types.
interface dqn_req_if;
   logic                     valid;
   logic                     ready;
   dqn_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dqn_rsp_if;
   logic                     valid;
   logic                     ready;
   dqn_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hdl/dqn_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Depends on dqn_pkg for widths.
module dqn_sqrt (
   input  logic                              clock,
   input  logic                              en,
   input  logic [dqn_pkg::SUM_W-1:0]         radicand,
   output logic [dqn_pkg::ROOT_W-1:0]        root
);
   localparam int unsigned REM_W = dqn_pkg::SUM_W + 2;

   logic [REM_W-1:0]              rem_ff  [dqn_pkg::ROOT_W];
   logic [dqn_pkg::ROOT_W-1:0]    root_ff [dqn_pkg::ROOT_W];

   for (genvar k = 0; k < dqn_pkg::ROOT_W; k++) begin : g_step
      localparam int unsigned B = dqn_pkg::ROOT_W - 1 - k;
      logic [REM_W-1:0]           rem_prev;
      logic [dqn_pkg::ROOT_W-1:0] root_prev;
      logic [REM_W-1:0]           cand;
      logic [REM_W-1:0]           rem_in;
      logic [dqn_pkg::ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = REM_W'(radicand);
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
      always_comb begin
         cand    = (REM_W'(root_prev) << (B + 1)) + (REM_W'(1) << (2 * B));
         rem_in  = rem_prev;
         root_in = root_prev;
         if (rem_prev >= cand) begin
            rem_in  = rem_prev - cand;
            root_in = root_prev | (dqn_pkg::ROOT_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[dqn_pkg::ROOT_W-1];

endmodule

[hdl/dqn_div.sv]
// Pipelined restoring divider: sat32(trunc((v << 16) / len)), one quotient bit per stage.
// Depends on dqn_pkg for widths and the saturation helper.
module dqn_div (
   input  logic                        clock,
   input  logic                        en,
   input  dqn_pkg::fixed_type          value,
   input  logic [dqn_pkg::ROOT_W-1:0]  len,
   output dqn_pkg::fixed_type          quot
);
   localparam int unsigned N = dqn_pkg::DIVIDEND_W;
   localparam int unsigned R = dqn_pkg::ROOT_W;

   logic [R-1:0] rem_ff [N];
   logic [N-1:0] num_ff [N];   // dividend shifts out the top, quotient fills the bottom
   logic [R-1:0] len_ff [N];
   logic         neg_ff [N];
   dqn_pkg::fixed_type quot_ff;

   logic [dqn_pkg::DATA_W-1:0] mag;
   assign mag = value[dqn_pkg::DATA_W-1] ? (~value + 1'b1) : value;

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [R-1:0] rem_prev;
      logic [N-1:0] num_prev;
      logic [R-1:0] len_prev;
      logic         neg_prev;
      logic [R:0]   trial;
      logic         qbit;
      logic [R-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = {mag, dqn_pkg::FRAC_W'(0)};
         assign len_prev = len;
         assign neg_prev = value[dqn_pkg::DATA_W-1];
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign len_prev = len_ff[k-1];
         assign neg_prev = neg_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, num_prev[N-1]};
         qbit   = (trial >= {1'b0, len_prev});
         rem_in = qbit ? R'(trial - {1'b0, len_prev}) : trial[R-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= {num_prev[N-2:0], qbit};
            len_ff[k] <= len_prev;
            neg_ff[k] <= neg_prev;
         end
      end
   end

   logic signed [dqn_pkg::WIDE_W-1:0] q_wide;
   always_comb begin
      q_wide = $signed({{(dqn_pkg::WIDE_W-N){1'b0}}, num_ff[N-1]});
      if (neg_ff[N-1]) begin
         q_wide = -q_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= dqn_pkg::sat_fixed(q_wide);
      end
   end

   assign quot = quot_ff;

endmodule

[hdl/dual_quaternion_normalize.sv]
// Dual quaternion normalizer, Q16.16: top level with the request/response pipeline.
// Depends on dqn_pkg, dqn_if, dqn_sqrt and dqn_div.
//
// Takes one dual quaternion per request and returns it normalized: both parts are divided
// by floor(sqrt(sum of squared real components)), and the dual part loses its component
// along the real part (dual - dot(real, dual) * real, products floored by 2^16). Every
// result saturates to 32 bits; a zero real part returns all zeros with zero_length set.
// The block is a fully pipelined datapath: one request is accepted every cycle, and each
// passes through stages 1 to 3, the square root (one root bit per stage), the eight
// dividers (one quotient bit per stage), stages A to C and the response register. The
// whole pipeline advances together; it holds only while a finished response waits on
// rsp ready, so no request is lost or repeated. The block keeps no state between requests.
module dual_quaternion_normalize (
   input  logic           clock,
   input  logic           reset,
   dqn_req_if.sink        req_chan,
   dqn_rsp_if.source      rsp_chan
);
   localparam int unsigned NC = dqn_pkg::COMP_NUM;
   localparam int unsigned RW = dqn_pkg::ROOT_W;
   localparam int unsigned DL = dqn_pkg::DIV_LAT;
   localparam int unsigned WW = dqn_pkg::WIDE_W;

   logic en;
   logic rsp_valid_ff;

   // Advance everything unless a finished response is stuck at the output.
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Stage 1: magnitudes squared.
   dqn_pkg::quat_type r_req, d_req;
   assign r_req = {req_chan.payload.real_z, req_chan.payload.real_y,
                   req_chan.payload.real_x, req_chan.payload.real_w};
   assign d_req = {req_chan.payload.dual_z, req_chan.payload.dual_y,
                   req_chan.payload.dual_x, req_chan.payload.dual_w};

   logic                          v1_ff, v2_ff, v3_ff;
   dqn_pkg::quat_type             r1_ff, d1_ff, r2_ff, d2_ff, r3_ff, d3_ff;
   logic [dqn_pkg::SQ_W-1:0]      sq1_ff [NC];
   logic [dqn_pkg::SUM_W-1:0]     ps2_ff [2];
   logic [dqn_pkg::SUM_W-1:0]     sum3_ff;
   logic [dqn_pkg::DATA_W-1:0]    mag    [NC];

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         mag[i] = r_req[i][dqn_pkg::DATA_W-1] ? (~r_req[i] + 1'b1) : r_req[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff <= r_req;
         d1_ff <= d_req;
         for (int i = 0; i < NC; i++) begin
            sq1_ff[i] <= mag[i] * mag[i];
         end
         // Stage 2: pairwise sums.
         r2_ff     <= r1_ff;
         d2_ff     <= d1_ff;
         ps2_ff[0] <= dqn_pkg::SUM_W'(sq1_ff[0]) + dqn_pkg::SUM_W'(sq1_ff[1]);
         ps2_ff[1] <= dqn_pkg::SUM_W'(sq1_ff[2]) + dqn_pkg::SUM_W'(sq1_ff[3]);
         // Stage 3: full sum of squares (at most 2^64).
         r3_ff     <= r2_ff;
         d3_ff     <= d2_ff;
         sum3_ff   <= ps2_ff[0] + ps2_ff[1];
      end
   end

   // Square root; carry the components alongside it.
   logic [RW-1:0] root;

   dqn_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (sum3_ff),
      .root     (root)
   );

   logic              vs_ff [RW];
   dqn_pkg::quat_type rs_ff [RW];
   dqn_pkg::quat_type ds_ff [RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RW; k++) begin
            vs_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vs_ff[0] <= v3_ff;
         for (int k = 1; k < RW; k++) begin
            vs_ff[k] <= vs_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rs_ff[0] <= r3_ff;
         ds_ff[0] <= d3_ff;
         for (int k = 1; k < RW; k++) begin
            rs_ff[k] <= rs_ff[k-1];
            ds_ff[k] <= ds_ff[k-1];
         end
      end
   end

   // Divide all eight components by the length.
   dqn_pkg::quat_type nr, nd;

   for (genvar i = 0; i < NC; i++) begin : g_div
      dqn_div u_div_real (
         .clock (clock),
         .en    (en),
         .value (rs_ff[RW-1][i]),
         .len   (root),
         .quot  (nr[i])
      );
      dqn_div u_div_dual (
         .clock (clock),
         .en    (en),
         .value (ds_ff[RW-1][i]),
         .len   (root),
         .quot  (nd[i])
      );
   end

   logic vd_ff [DL];
   logic zd_ff [DL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DL; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vd_ff[0] <= vs_ff[RW-1];
         for (int k = 1; k < DL; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zd_ff[0] <= (root == '0);
         for (int k = 1; k < DL; k++) begin
            zd_ff[k] <= zd_ff[k-1];
         end
      end
   end

   // Stage A: component products for the dot.
   logic                      va_ff, vb_ff, vc_ff;
   logic                      za_ff, zb_ff, zc_ff;
   dqn_pkg::quat_type         nra_ff, nda_ff, nrb_ff, ndb_ff, nrc_ff, ndc_ff;
   logic signed [63:0]        pa_ff [NC];
   dqn_pkg::fixed_type        dotb_ff;
   logic signed [63:0]        pc_ff [NC];
   logic signed [WW-1:0]      dot_wide;

   // floor(p / 2^16) is the arithmetic shift: the upper bits sign extended.
   always_comb begin
      dot_wide = '0;
      for (int i = 0; i < NC; i++) begin
         dot_wide = dot_wide + $signed({{(WW-48){pa_ff[i][63]}}, pa_ff[i][63:16]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= vd_ff[DL-1];
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         za_ff  <= zd_ff[DL-1];
         nra_ff <= nr;
         nda_ff <= nd;
         for (int i = 0; i < NC; i++) begin
            pa_ff[i] <= 64'(nr[i]) * 64'(nd[i]);
         end
         // Stage B: saturated dot product.
         zb_ff   <= za_ff;
         nrb_ff  <= nra_ff;
         ndb_ff  <= nda_ff;
         dotb_ff <= dqn_pkg::sat_fixed(dot_wide);
         // Stage C: dot times each real component.
         zc_ff   <= zb_ff;
         nrc_ff  <= nrb_ff;
         ndc_ff  <= ndb_ff;
         for (int i = 0; i < NC; i++) begin
            pc_ff[i] <= 64'(dotb_ff) * 64'(nrb_ff[i]);
         end
      end
   end

   // Stage D: subtract from the dual part, saturate, force zeros for a zero length.
   dqn_pkg::quat_type       od;
   dqn_pkg::rsp_payload_type rsp_in, rsp_ff;

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         od[i] = dqn_pkg::sat_fixed($signed({{(WW-32){ndc_ff[i][31]}}, ndc_ff[i]})
                                  - $signed({{(WW-48){pc_ff[i][63]}}, pc_ff[i][63:16]}));
      end
      rsp_in.out_real_w  = zc_ff ? '0 : nrc_ff[0];
      rsp_in.out_real_x  = zc_ff ? '0 : nrc_ff[1];
      rsp_in.out_real_y  = zc_ff ? '0 : nrc_ff[2];
      rsp_in.out_real_z  = zc_ff ? '0 : nrc_ff[3];
      rsp_in.out_dual_w  = zc_ff ? '0 : od[0];
      rsp_in.out_dual_x  = zc_ff ? '0 : od[1];
      rsp_in.out_dual_y  = zc_ff ? '0 : od[2];
      rsp_in.out_dual_z  = zc_ff ? '0 : od[3];
      rsp_in.zero_length = zc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // A zero-length response carries nothing but the flag.
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.zero_length |->
         rsp_ff.out_real_w == '0 && rsp_ff.out_real_x == '0 &&
         rsp_ff.out_real_y == '0 && rsp_ff.out_real_z == '0 &&
         rsp_ff.out_dual_w == '0 && rsp_ff.out_dual_x == '0 &&
         rsp_ff.out_dual_y == '0 && rsp_ff.out_dual_z == '0)
      else $error("zero-length response with nonzero fields");

   // While stalled, no pipeline valid moves.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vs_ff[0]) && $stable(vd_ff[0]) && $stable(vc_ff))
      else $error("pipeline advanced during stall");

   // A response leaves only through a handshake.
   a_rsp_leaves: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_chan.ready))
      else $error("response dropped without handshake");

   // A request accepted now is in stage one next cycle.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && en |=> v1_ff)
      else $error("accepted request lost at entry");

endmodule

[tb/dqn_checker.sv]
// Checker for the dual quaternion normalizer: watches both channels, predicts each response.
// Depends on dqn_pkg and the dqn_if interfaces.
module dqn_checker (
   input  logic      clock,
   input  logic      reset,
   dqn_req_if.sink   req_mon,
   dqn_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   dqn_pkg::rsp_payload_type normalized_q[$];

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor16(input longint v);
      return v >>> 16;
   endfunction

   function automatic logic [32:0] root_of(input logic [64:0] n);
      logic [64:0] rem, acc, bitv;
      rem = n;
      acc = 0;
      bitv = 65'd1 << 64;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= acc + bitv) begin
            rem = rem - (acc + bitv);
            acc = (acc >> 1) + bitv;
         end else begin
            acc = acc >> 1;
         end
         bitv = bitv >> 2;
      end
      return acc[32:0];
   endfunction

   function automatic longint scale_by(input longint v, input logic [32:0] len);
      logic [63:0] m, q;
      m = (v < 0) ? -v : v;
      q = (m << 16) / {31'd0, len};
      return clamp32((v < 0) ? -longint'(q) : longint'(q));
   endfunction

   function automatic dqn_pkg::rsp_payload_type normalize(input dqn_pkg::req_payload_type p);
      dqn_pkg::rsp_payload_type o;
      longint rv[4], dv[4], nr[4], nd[4], dp;
      logic [64:0] sumsq;
      logic [63:0] m;
      logic [32:0] len;
      rv = '{p.real_w, p.real_x, p.real_y, p.real_z};
      dv = '{p.dual_w, p.dual_x, p.dual_y, p.dual_z};
      sumsq = 0;
      foreach (rv[i]) begin
         m = (rv[i] < 0) ? -rv[i] : rv[i];
         sumsq = sumsq + m * m;
      end
      len = root_of(sumsq);
      o = '0;
      if (len == 0) begin
         o.zero_length = 1'b1;
         return o;
      end
      dp = 0;
      foreach (rv[i]) begin
         nr[i] = scale_by(rv[i], len);
         nd[i] = scale_by(dv[i], len);
         dp += floor16(nr[i] * nd[i]);
      end
      dp = clamp32(dp);
      o.out_real_w = dqn_pkg::fixed_type'(nr[0]);
      o.out_real_x = dqn_pkg::fixed_type'(nr[1]);
      o.out_real_y = dqn_pkg::fixed_type'(nr[2]);
      o.out_real_z = dqn_pkg::fixed_type'(nr[3]);
      o.out_dual_w = dqn_pkg::fixed_type'(clamp32(nd[0] - floor16(dp * nr[0])));
      o.out_dual_x = dqn_pkg::fixed_type'(clamp32(nd[1] - floor16(dp * nr[1])));
      o.out_dual_y = dqn_pkg::fixed_type'(clamp32(nd[2] - floor16(dp * nr[2])));
      o.out_dual_z = dqn_pkg::fixed_type'(clamp32(nd[3] - floor16(dp * nr[3])));
      return o;
   endfunction

   always @(posedge clock) begin
      dqn_pkg::rsp_payload_type want;
      if (reset) begin
         fail_count <= 0;
         normalized_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) normalized_q.push_back(normalize(req_mon.payload));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (normalized_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", rsp_mon.payload);
               fail_count <= fail_count + 1;
            end else begin
               want = normalized_q.pop_front();
               if (rsp_mon.payload !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %h actual %h", want, rsp_mon.payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= normalized_q.size();
   end
endmodule

[tb/testbench.sv]
// Top of the normalizer testbench: clock, reset, request stimulus, response stalls, verdict.
// Depends on dqn_pkg, dqn_if, dqn_checker and the block itself.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   bit   steady;   // set during the stretch with no idling on either side

   dqn_req_if req_chan();
   dqn_rsp_if rsp_chan();

   dual_quaternion_normalize i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   dqn_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side about 11 percent of the time, never while steady.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= steady || ($urandom_range(99) >= 11);
      end
   end

   // Pick a component value, biased toward the extremes and small magnitudes.
   function automatic dqn_pkg::fixed_type pick_value();
      unique case ($urandom_range(7))
         0: return dqn_pkg::fixed_type'(32'h8000_0000);
         1: return dqn_pkg::fixed_type'(32'h7fff_ffff);
         2: return dqn_pkg::fixed_type'(0);
         3: return dqn_pkg::fixed_type'($signed($urandom_range(131072)) - 65536);
         4: return dqn_pkg::fixed_type'($signed($urandom_range(2000)) - 1000);
         default: return dqn_pkg::fixed_type'($urandom);
      endcase
   endfunction

   // Hold one request until it is accepted, optionally idling first.
   task automatic send_request(input dqn_pkg::req_payload_type p);
      while (!steady && $urandom_range(99) < 11) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin
      dqn_pkg::req_payload_type p;
      dqn_pkg::fixed_type       lo, hi;
      int                       wait_cycles;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      steady = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      lo = dqn_pkg::fixed_type'(32'h8000_0000);
      hi = dqn_pkg::fixed_type'(32'h7fff_ffff);
      // Directed: zero length, largest length, unit values, saturating quotients.
      send_request('{0, 0, 0, 0, 0, 0, 0, 0});
      send_request('{0, 0, 0, 0, hi, lo, 5, -5});
      send_request('{lo, lo, lo, lo, lo, lo, lo, lo});
      send_request('{lo, lo, lo, lo, hi, hi, hi, hi});
      send_request('{hi, hi, hi, hi, hi, lo, hi, lo});
      send_request('{65536, 0, 0, 0, 0, 65536, 0, 0});
      send_request('{1, 0, 0, 0, hi, lo, hi, lo});
      send_request('{0, 0, 0, -1, 1, -1, 0, 0});
      send_request('{0, 1, 1, 0, lo, hi, -1, 1});
      send_request('{hi, 0, 0, 0, -1, -1, -1, -1});
      send_request('{lo, 0, 0, 0, 65536, -65536, 32768, -32768});
      send_request('{-65536, 65536, -65536, 65536, hi, hi, lo, lo});
      send_request('{3, -4, 0, 0, 100, 200, -300, 400});
      send_request('{40000, 30000, -20000, 10000, 12345, -6789, 999, -1});
      send_request('{hi, lo, hi, lo, 0, 0, 0, 0});
      send_request('{1, 1, 1, 1, 1, 1, 1, 1});

      for (int n = 0; n < 500; n++) begin
         steady = (n >= 200 && n < 300);
         p.real_x = pick_value(); p.real_y = pick_value(); p.real_z = pick_value();
         p.real_w = pick_value();
         p.dual_w = pick_value(); p.dual_x = pick_value();
         p.dual_y = pick_value(); p.dual_z = pick_value();
         if ($urandom_range(19) == 0) begin
            p.real_w = 0; p.real_x = 0; p.real_y = 0; p.real_z = 0;
         end
         send_request(p);
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      // Drain: wait for every response, then let the pipeline run on before the verdict.
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #2ms;
      $display("testbench: done, errors");
      $finish;
   end
endmodule
